>>> sv/kclc_pkg.sv
package kclc_pkg;

  // Code length and the counter/index widths derived from it
  localparam int CODE_DIGITS = 4;
  localparam int CNT_W       = $clog2(CODE_DIGITS + 1);
  localparam int IDX_W       = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;

  // Fixed field widths
  localparam int SAMPLE_W = 12;
  localparam int TIMER_W  = 16;
  localparam int CHAR_W   = 8;
  localparam int DIGIT_W  = 3;
  localparam int STATE_W  = 3;
  localparam int COUNT_W  = 3;
  localparam int POS_W    = 2;
  localparam int REQ_W    = 2;
  localparam int IN_W     = 24;
  localparam int OUT_W    = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration reset values
  localparam logic [TIMER_W-1:0]  ENTRY_TIMEOUT_RST = 16'd50000;
  localparam logic [TIMER_W-1:0]  LONG_PRESS_RST    = 16'd20000;
  localparam logic [SAMPLE_W-1:0] THRESH_RIGHT_RST  = 12'd50;
  localparam logic [SAMPLE_W-1:0] THRESH_UP_RST     = 12'd500;
  localparam logic [SAMPLE_W-1:0] THRESH_DOWN_RST   = 12'd1100;
  localparam logic [SAMPLE_W-1:0] THRESH_LEFT_RST   = 12'd1600;
  localparam logic [SAMPLE_W-1:0] THRESH_SELECT_RST = 12'd2500;

  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

  // Setup characters accepted as master digits
  localparam logic [CHAR_W-1:0] CHAR_FIRST = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_LAST  = 8'h34;

  // Decoded ladder buttons
  localparam logic [DIGIT_W-1:0] KEY_SELECT = 3'd0;
  localparam logic [DIGIT_W-1:0] KEY_LEFT   = 3'd1;
  localparam logic [DIGIT_W-1:0] KEY_UP     = 3'd2;
  localparam logic [DIGIT_W-1:0] KEY_DOWN   = 3'd3;
  localparam logic [DIGIT_W-1:0] KEY_RIGHT  = 3'd4;
  localparam logic [DIGIT_W-1:0] KEY_NONE   = 3'd5;

  typedef enum logic [STATE_W-1:0] {
    MODE_SETUP    = 3'd0,
    MODE_IDLE     = 3'd1,
    MODE_ENTERING = 3'd2,
    MODE_UNLOCKED = 3'd3,
    MODE_ERROR    = 3'd4,
    MODE_TIMEOUT  = 3'd5
  } mode_e;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK  = 2'd0,
    REQ_POLL  = 2'd1,
    REQ_SETUP = 2'd2
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENTRY_TIMEOUT = 3'd0,
    CFG_LONG_PRESS    = 3'd1,
    CFG_THRESH_RIGHT  = 3'd2,
    CFG_THRESH_UP     = 3'd3,
    CFG_THRESH_DOWN   = 3'd4,
    CFG_THRESH_LEFT   = 3'd5,
    CFG_THRESH_SELECT = 3'd6
  } cfg_idx_e;

  // One result item
  typedef struct packed {
    logic [STATE_W-1:0] lock_state;
    logic [COUNT_W-1:0] digits_entered;
    logic               star_valid;
    logic [POS_W-1:0]   star_position;
    logic               echo_valid;
    logic [CHAR_W-1:0]  echo_char;
    logic               code_set;
  } result_t;

endpackage

>>> sv/keypad_code_lock_controller_core.sv
// Keypad code lock controller.
// The result of an item is written to the output register when the item is accepted.
// Throughput: one item per cycle; the state update is a single pass of logic from the
// state registers to the result register, and the input stalls only while a result waits.
// Reset: asynchronous, active low; the lock starts in setup mode with default
// configuration, and the master and entered digits stay unknown until written.
module keypad_code_lock_controller_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input stream
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [11:0] ladder_sample, [12] reset_button_level, [20:13] setup_char, [23:21] zero
  input  logic [kclc_pkg::IN_W-1:0]      s_axis_tdata_i,
  // [1:0] req_type
  input  logic [kclc_pkg::REQ_W-1:0]     s_axis_tuser_i,
  // Result stream
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [2:0] lock_state, [5:3] digits_entered, [6] star_valid, [8:7] star_position,
  // [9] echo_valid, [17:10] echo_char, [18] code_set, [23:19] zero
  output logic [kclc_pkg::OUT_W-1:0]     m_axis_tdata_o,
  // Configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [kclc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [kclc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import kclc_pkg::*;

  // Configuration registers
  logic [TIMER_W-1:0]  entry_timeout_q, long_press_q;
  logic [SAMPLE_W-1:0] thresh_right_q, thresh_up_q, thresh_down_q;
  logic [SAMPLE_W-1:0] thresh_left_q, thresh_select_q;

  // Lock state
  mode_e              mode_q, mode_d;
  logic [CNT_W-1:0]   setup_count_q, setup_count_d;
  logic [CNT_W-1:0]   entry_count_q, entry_count_d;
  logic [TIMER_W-1:0] entry_timer_q, entry_timer_d;
  logic [DIGIT_W-1:0] prev_button_q, prev_button_d;
  logic               hold_armed_q, hold_armed_d;
  logic [TIMER_W-1:0] hold_timer_q, hold_timer_d;
  logic [DIGIT_W-1:0] master_q  [CODE_DIGITS];
  logic [DIGIT_W-1:0] entered_q [CODE_DIGITS];

  // Result register
  logic    out_valid_q;
  result_t out_q, result_d;

  // Input fields
  req_e                req;
  logic [SAMPLE_W-1:0] sample;
  logic                level;
  logic [CHAR_W-1:0]   setup_char;
  logic                in_fire, cfg_fire;

  // Decisions of the current item
  logic [DIGIT_W-1:0] btn;
  logic               press;
  logic               digit_wr, master_wr;
  logic [IDX_W-1:0]   digit_idx, master_idx;
  logic               codes_match;
  logic               echo_v, code_set_v;

  assign req        = req_e'(s_axis_tuser_i);
  assign sample     = s_axis_tdata_i[11:0];
  assign level      = s_axis_tdata_i[12];
  assign setup_char = s_axis_tdata_i[20:13];

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;
  assign cfg_fire        = cfg_valid_i;

  // Ladder decode against the threshold chain
  always_comb begin
    if (sample < thresh_right_q) begin
      btn = KEY_RIGHT;
    end else if (sample < thresh_up_q) begin
      btn = KEY_UP;
    end else if (sample < thresh_down_q) begin
      btn = KEY_DOWN;
    end else if (sample < thresh_left_q) begin
      btn = KEY_LEFT;
    end else if (sample < thresh_select_q) begin
      btn = KEY_SELECT;
    end else begin
      btn = KEY_NONE;
    end
  end

  assign press = (btn != KEY_NONE) && (prev_button_q == KEY_NONE);

  // Entry restarts at position zero on the first press from idle
  assign digit_idx  = (mode_q == MODE_IDLE) ? '0 : entry_count_q[IDX_W-1:0];
  assign master_idx = setup_count_q[IDX_W-1:0];

  // Compare entry with the master code, the digit being written included
  always_comb begin
    logic [DIGIT_W-1:0] cand;
    codes_match = 1'b1;
    for (int i = 0; i < CODE_DIGITS; i++) begin
      cand = (IDX_W'(i) == digit_idx) ? btn : entered_q[i];
      if (cand != master_q[i]) codes_match = 1'b0;
    end
  end

  // Next state
  always_comb begin
    mode_d        = mode_q;
    setup_count_d = setup_count_q;
    entry_count_d = entry_count_q;
    entry_timer_d = entry_timer_q;
    prev_button_d = prev_button_q;
    hold_armed_d  = hold_armed_q;
    hold_timer_d  = hold_timer_q;
    digit_wr      = 1'b0;
    master_wr     = 1'b0;
    echo_v        = 1'b0;
    code_set_v    = 1'b0;
    unique case (req)
      REQ_TICK: begin
        if (mode_q == MODE_ENTERING) begin
          if (entry_timer_q >= entry_timeout_q) begin
            mode_d = MODE_TIMEOUT;
          end else if (entry_timer_q != TIMER_MAX) begin
            entry_timer_d = entry_timer_q + 1'b1;
          end
        end
        if (hold_armed_q && hold_timer_q != TIMER_MAX) begin
          hold_timer_d = hold_timer_q + 1'b1;
        end
      end
      REQ_POLL: begin
        if (press) begin
          if (mode_q == MODE_ERROR || mode_q == MODE_TIMEOUT) begin
            mode_d        = MODE_IDLE;
            entry_count_d = '0;
          end else if (mode_q == MODE_IDLE || mode_q == MODE_ENTERING) begin
            if (mode_q == MODE_IDLE) begin
              mode_d        = MODE_ENTERING;
              entry_timer_d = '0;
              entry_count_d = '0;
            end
            if (mode_q == MODE_IDLE || entry_count_q < CNT_W'(CODE_DIGITS)) begin
              digit_wr      = 1'b1;
              entry_count_d = CNT_W'(digit_idx) + 1'b1;
              if (CNT_W'(digit_idx) == CNT_W'(CODE_DIGITS - 1)) begin
                mode_d = codes_match ? MODE_UNLOCKED : MODE_ERROR;
              end
            end
          end
        end
        prev_button_d = btn;
        // Long-press reset, evaluated after the button
        if (level) begin
          if (!hold_armed_q) begin
            hold_armed_d = 1'b1;
            hold_timer_d = '0;
          end else if (hold_timer_q > long_press_q) begin
            if (mode_q != MODE_SETUP) begin
              mode_d        = MODE_IDLE;
              entry_count_d = '0;
            end
            hold_armed_d = 1'b0;
          end
        end else begin
          hold_armed_d = 1'b0;
        end
      end
      REQ_SETUP: begin
        if (mode_q == MODE_SETUP && setup_char >= CHAR_FIRST && setup_char <= CHAR_LAST &&
            setup_count_q < CNT_W'(CODE_DIGITS)) begin
          master_wr     = 1'b1;
          echo_v        = 1'b1;
          setup_count_d = setup_count_q + 1'b1;
          if (setup_count_q == CNT_W'(CODE_DIGITS - 1)) begin
            entry_count_d = '0;
            mode_d        = MODE_IDLE;
            code_set_v    = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Result fields
  always_comb begin
    result_d.lock_state     = mode_d;
    result_d.digits_entered = COUNT_W'(entry_count_d);
    result_d.star_valid     = digit_wr;
    result_d.star_position  = digit_wr ? POS_W'(digit_idx) : '0;
    result_d.echo_valid     = echo_v;
    result_d.echo_char      = echo_v ? setup_char : '0;
    result_d.code_set       = code_set_v;
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_timeout_q <= ENTRY_TIMEOUT_RST;
      long_press_q    <= LONG_PRESS_RST;
      thresh_right_q  <= THRESH_RIGHT_RST;
      thresh_up_q     <= THRESH_UP_RST;
      thresh_down_q   <= THRESH_DOWN_RST;
      thresh_left_q   <= THRESH_LEFT_RST;
      thresh_select_q <= THRESH_SELECT_RST;
    end else if (cfg_fire) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ENTRY_TIMEOUT: entry_timeout_q <= cfg_data_i;
        CFG_LONG_PRESS:    long_press_q    <= cfg_data_i;
        CFG_THRESH_RIGHT:  thresh_right_q  <= cfg_data_i[SAMPLE_W-1:0];
        CFG_THRESH_UP:     thresh_up_q     <= cfg_data_i[SAMPLE_W-1:0];
        CFG_THRESH_DOWN:   thresh_down_q   <= cfg_data_i[SAMPLE_W-1:0];
        CFG_THRESH_LEFT:   thresh_left_q   <= cfg_data_i[SAMPLE_W-1:0];
        CFG_THRESH_SELECT: thresh_select_q <= cfg_data_i[SAMPLE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_SETUP;
      setup_count_q <= '0;
      entry_count_q <= '0;
      entry_timer_q <= '0;
      prev_button_q <= KEY_NONE;
      hold_armed_q  <= 1'b0;
      hold_timer_q  <= '0;
    end else if (in_fire) begin
      mode_q        <= mode_d;
      setup_count_q <= setup_count_d;
      entry_count_q <= entry_count_d;
      entry_timer_q <= entry_timer_d;
      prev_button_q <= prev_button_d;
      hold_armed_q  <= hold_armed_d;
      hold_timer_q  <= hold_timer_d;
    end
  end

  // Digit stores, no reset
  always_ff @(posedge clk_i) begin
    if (in_fire && digit_wr) entered_q[digit_idx] <= btn;
    if (in_fire && master_wr) master_q[master_idx] <= setup_char[DIGIT_W-1:0];
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      out_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) out_q <= result_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OUT_W - $bits(result_t))'(0),
                            out_q.code_set, out_q.echo_char, out_q.echo_valid,
                            out_q.star_position, out_q.star_valid,
                            out_q.digits_entered, out_q.lock_state};

  // Completing the master code always leaves the lock idle with no digits
  a_code_set_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.code_set |->
      out_q.lock_state == MODE_IDLE && out_q.digits_entered == '0)
    else $error("code_set without idle state");

  // Digit count never passes the code length
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_count_q <= CNT_W'(CODE_DIGITS) && setup_count_q <= CNT_W'(CODE_DIGITS))
    else $error("digit count out of range");

  // Setup is left only once the full master code is stored
  a_setup_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q != MODE_SETUP |-> setup_count_q == CNT_W'(CODE_DIGITS))
    else $error("left setup with incomplete master code");

  // A digit write is always reported as a star result, never mixed with an echo
  a_star_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && digit_wr |=> out_q.star_valid && !out_q.echo_valid)
    else $error("star result lost or mixed with echo");

endmodule

>>> bench/keypad_code_lock_controller_core_tb.sv
`timescale 1ns / 1ps

module keypad_code_lock_controller_core_tb;
  import kclc_pkg::*;

  // Request code with no defined action
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_W-1:0]       s_axis_tdata_i = '0;
  logic [REQ_W-1:0]      s_axis_tuser_i = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_W-1:0]      m_axis_tdata_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  keypad_code_lock_controller_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Lock model state, mirrors the block after reset
  mode_e              lk_mode = MODE_SETUP;
  logic [DIGIT_W-1:0] master_dig [CODE_DIGITS];
  logic [DIGIT_W-1:0] entry_code [CODE_DIGITS];
  int                 setup_cnt = 0;
  int                 entry_cnt = 0;
  int                 entry_tmr = 0;
  int                 hold_tmr = 0;
  bit                 hold_on = 1'b0;
  logic [DIGIT_W-1:0] prev_key = KEY_NONE;

  // Configuration copy; thresholds in decode priority order
  int cfg_entry_timeout = ENTRY_TIMEOUT_RST;
  int cfg_long_press    = LONG_PRESS_RST;
  int thr [5] = '{THRESH_RIGHT_RST, THRESH_UP_RST, THRESH_DOWN_RST,
                  THRESH_LEFT_RST, THRESH_SELECT_RST};

  result_t lock_results_due [$];
  int      fail_count = 0;
  int      items_sent = 0;
  int      src_idle_pct = 10;
  int      sink_idle_pct = 70;
  // Hold-off request from the test flow; the receiver counts it down itself
  int      sink_hold_len = 0;
  bit      sink_hold_req = 1'b0;
  bit      sink_hold_seen = 1'b0;
  int      sink_hold_left = 0;

  function automatic logic [DIGIT_W-1:0] band_button(int i);
    case (i)
      0:       return KEY_RIGHT;
      1:       return KEY_UP;
      2:       return KEY_DOWN;
      3:       return KEY_LEFT;
      default: return KEY_SELECT;
    endcase
  endfunction

  function automatic logic [DIGIT_W-1:0] decode_button(logic [SAMPLE_W-1:0] sample);
    int i;
    for (i = 0; i < 5; i++) begin
      if (sample < thr[i]) return band_button(i);
    end
    return KEY_NONE;
  endfunction

  // Pick a ladder sample that decodes as btn, biased toward band edges
  function automatic logic [SAMPLE_W-1:0] sample_for(logic [DIGIT_W-1:0] btn);
    int lo;
    int hi;
    int i;
    lo = 0;
    for (i = 0; i < 5; i++) begin
      if (band_button(i) == btn && lo < thr[i]) begin
        hi = thr[i] - 1;
        case ($urandom_range(7))
          0:       return SAMPLE_W'(lo);
          1:       return SAMPLE_W'(hi);
          default: return SAMPLE_W'($urandom_range(hi, lo));
        endcase
      end
      if (thr[i] > lo) lo = thr[i];
    end
    if (btn == KEY_NONE) begin
      if ($urandom_range(3) == 0) return '1;
      return SAMPLE_W'($urandom_range(4095, lo));
    end
    // band empty under the current thresholds
    return SAMPLE_W'($urandom_range(4095));
  endfunction

  // Advance the lock model by one accepted item and return its result
  function automatic result_t lock_step(logic [REQ_W-1:0] req, logic [SAMPLE_W-1:0] sample,
                                        logic level, logic [CHAR_W-1:0] ch);
    result_t            r;
    logic [DIGIT_W-1:0] btn;
    bit                 same;
    int                 i;
    r = '0;
    case (req)
      REQ_TICK: begin
        if (lk_mode == MODE_ENTERING) begin
          if (entry_tmr >= cfg_entry_timeout) lk_mode = MODE_TIMEOUT;
          else if (entry_tmr < TIMER_MAX) entry_tmr++;
        end
        if (hold_on && hold_tmr < TIMER_MAX) hold_tmr++;
      end
      REQ_POLL: begin
        btn = decode_button(sample);
        // only a none-to-button change counts as a press
        if (btn != KEY_NONE && prev_key == KEY_NONE) begin
          if (lk_mode == MODE_ERROR || lk_mode == MODE_TIMEOUT) begin
            entry_cnt = 0;
            lk_mode = MODE_IDLE;
          end else if (lk_mode == MODE_IDLE || lk_mode == MODE_ENTERING) begin
            if (lk_mode == MODE_IDLE) begin
              lk_mode = MODE_ENTERING;
              entry_tmr = 0;
              entry_cnt = 0;
            end
            if (entry_cnt < CODE_DIGITS) begin
              entry_code[entry_cnt] = btn;
              r.star_valid = 1'b1;
              r.star_position = POS_W'(entry_cnt);
              entry_cnt++;
              if (entry_cnt == CODE_DIGITS) begin
                same = 1'b1;
                for (i = 0; i < CODE_DIGITS; i++) begin
                  if (master_dig[i] != entry_code[i]) same = 1'b0;
                end
                lk_mode = same ? MODE_UNLOCKED : MODE_ERROR;
              end
            end
          end
        end
        prev_key = btn;
        // long-press reset button, evaluated after the keypad
        if (level) begin
          if (!hold_on) begin
            hold_on = 1'b1;
            hold_tmr = 0;
          end else if (hold_tmr > cfg_long_press) begin
            if (lk_mode != MODE_SETUP) begin
              entry_cnt = 0;
              lk_mode = MODE_IDLE;
            end
            hold_on = 1'b0;
          end
        end else begin
          hold_on = 1'b0;
        end
      end
      REQ_SETUP: begin
        if (lk_mode == MODE_SETUP && ch >= CHAR_FIRST && ch <= CHAR_LAST &&
            setup_cnt < CODE_DIGITS) begin
          master_dig[setup_cnt] = DIGIT_W'(ch - CHAR_FIRST);
          setup_cnt++;
          r.echo_valid = 1'b1;
          r.echo_char = ch;
          if (setup_cnt == CODE_DIGITS) begin
            entry_cnt = 0;
            lk_mode = MODE_IDLE;
            r.code_set = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.lock_state = lk_mode;
    r.digits_entered = COUNT_W'(entry_cnt);
    return r;
  endfunction

  // Result receiver: random stalls plus an optional long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (sink_hold_req != sink_hold_seen) begin
      sink_hold_seen = sink_hold_req;
      sink_hold_left = sink_hold_len - 1;
      m_axis_tready_i <= 1'b0;
    end else if (sink_hold_left > 0) begin
      sink_hold_left = sink_hold_left - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Compare each result transaction against the oldest prediction
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (lock_results_due.size() == 0) begin
        $error("result with nothing expected: %h", m_axis_tdata_o);
        fail_count++;
      end else begin
        want = lock_results_due.pop_front();
        check_field("lock_state", want.lock_state, m_axis_tdata_o[2:0]);
        check_field("digits_entered", want.digits_entered, m_axis_tdata_o[5:3]);
        check_field("star_valid", want.star_valid, m_axis_tdata_o[6]);
        check_field("star_position", want.star_position, m_axis_tdata_o[8:7]);
        check_field("echo_valid", want.echo_valid, m_axis_tdata_o[9]);
        check_field("echo_char", want.echo_char, m_axis_tdata_o[17:10]);
        check_field("code_set", want.code_set, m_axis_tdata_o[18]);
      end
    end
  end

  // Offer one item, predict its result once the transaction completes
  task automatic send_item(logic [REQ_W-1:0] req, logic [SAMPLE_W-1:0] sample, logic level,
                           logic [CHAR_W-1:0] ch);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(IN_W - 21){1'b0}}, ch, level, sample};
    s_axis_tuser_i  <= req;
    do @(posedge clk_i); while (!s_axis_tready_o);
    lock_results_due.push_back(lock_step(req, sample, level, ch));
    items_sent++;
  endtask

  task automatic send_tick();
    send_item(REQ_TICK, SAMPLE_W'($urandom_range(4095)), 1'($urandom_range(1)),
              CHAR_W'($urandom_range(255)));
  endtask

  task automatic send_poll(logic [SAMPLE_W-1:0] sample, logic level);
    send_item(REQ_POLL, sample, level, CHAR_W'($urandom_range(255)));
  endtask

  task automatic send_setup(logic [CHAR_W-1:0] ch);
    send_item(REQ_SETUP, SAMPLE_W'($urandom_range(4095)), 1'($urandom_range(1)), ch);
  endtask

  task automatic send_noise();
    logic [CHAR_W-1:0] ch;
    ch = $urandom_range(1) ? CHAR_W'(CHAR_FIRST + $urandom_range(4)) : CHAR_W'($urandom_range(255));
    send_item(REQ_W'($urandom_range(3)), SAMPLE_W'($urandom_range(4095)),
              1'($urandom_range(1)), ch);
  endtask

  // Press, sometimes hold over a second poll, then release
  task automatic press_digit(logic [DIGIT_W-1:0] d, logic level);
    send_poll(sample_for(d), level);
    if ($urandom_range(4) == 0) send_poll(sample_for(d), level);
    send_poll(sample_for(KEY_NONE), level);
  endtask

  // Hold the reset button past the long-press limit
  task automatic long_press();
    int n;
    send_poll(sample_for(KEY_NONE), 1'b1);
    for (n = 0; n <= cfg_long_press; n++) send_tick();
    send_poll(sample_for(KEY_NONE), 1'b1);
  endtask

  // Stop offering and wait for every outstanding result
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (lock_results_due.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Write all registers; only called with the block drained
  task automatic load_config(int entry_to, int long_p, int t0, int t1, int t2, int t3, int t4);
    cfg_idx_e idx;
    int       v;
    idx = idx.first();
    repeat (idx.num()) begin
      case (idx)
        CFG_ENTRY_TIMEOUT: v = entry_to;
        CFG_LONG_PRESS:    v = long_p;
        CFG_THRESH_RIGHT:  v = t0;
        CFG_THRESH_UP:     v = t1;
        CFG_THRESH_DOWN:   v = t2;
        CFG_THRESH_LEFT:   v = t3;
        default:           v = t4;
      endcase
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= CFG_DATA_W'(v);
      do @(posedge clk_i); while (!cfg_ready_o);
      case (idx)
        CFG_ENTRY_TIMEOUT: cfg_entry_timeout = v & 16'hFFFF;
        CFG_LONG_PRESS:    cfg_long_press = v & 16'hFFFF;
        CFG_THRESH_RIGHT:  thr[0] = v & 12'hFFF;
        CFG_THRESH_UP:     thr[1] = v & 12'hFFF;
        CFG_THRESH_DOWN:   thr[2] = v & 12'hFFF;
        CFG_THRESH_LEFT:   thr[3] = v & 12'hFFF;
        default:           thr[4] = v & 12'hFFF;
      endcase
      idx = idx.next();
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Setup mode: ignored requests, bad characters, hold expiry, code load
  task automatic test_setup();
    send_tick();
    send_item(REQ_UNUSED, '1, 1'b1, '1);
    send_poll('0, 1'b1);
    send_tick();
    send_tick();
    send_poll('1, 1'b1);
    send_poll('1, 1'b0);
    send_setup(CHAR_W'(CHAR_FIRST - 1));
    send_setup(CHAR_W'(CHAR_LAST + 1));
    send_setup('0);
    send_setup('1);
    send_setup(CHAR_FIRST);
    send_setup(CHAR_LAST);
    send_setup(CHAR_W'(CHAR_FIRST + $urandom_range(4)));
    send_setup(CHAR_W'(CHAR_FIRST + $urandom_range(4)));
    send_setup(CHAR_W'(CHAR_FIRST + 1));
  endtask

  // Correct code with a held first key, then a press while unlocked
  task automatic test_code_entry();
    int i;
    send_poll(sample_for(master_dig[0]), 1'b0);
    send_poll(sample_for(master_dig[0]), 1'b0);
    send_poll('1, 1'b0);
    for (i = 1; i < CODE_DIGITS; i++) press_digit(master_dig[i], 1'b0);
    send_poll(sample_for(KEY_SELECT), 1'b0);
    send_poll('1, 1'b0);
  endtask

  // Release disarms the hold; a full hold returns to idle
  task automatic test_long_press();
    send_poll('1, 1'b1);
    send_poll('1, 1'b0);
    repeat (3) send_tick();
    long_press();
  endtask

  // Entry timeout, press out of timeout, wrong code, press out of error
  task automatic test_timeout();
    int i;
    press_digit(master_dig[0], 1'b0);
    repeat (3) send_tick();
    press_digit(KEY_RIGHT, 1'b0);
    for (i = 0; i < CODE_DIGITS; i++) begin
      press_digit(i == 0 ? DIGIT_W'((master_dig[0] + 1) % 5) : master_dig[i], 1'b0);
    end
    press_digit(KEY_LEFT, 1'b0);
  endtask

  // Long receiver hold-off while items keep coming, then a full drain
  task automatic test_backpressure();
    sink_hold_len = 200;
    sink_hold_req = !sink_hold_req;
    repeat (30) send_noise();
    wait_drained();
  endtask

  // One entry attempt with random pacing, then recovery to idle
  task automatic run_attempt();
    logic [DIGIT_W-1:0] d;
    bit                 use_master;
    int                 i;
    use_master = $urandom_range(1);
    for (i = 0; i < CODE_DIGITS; i++) begin
      d = use_master ? master_dig[i] : DIGIT_W'($urandom_range(4));
      press_digit(d, $urandom_range(9) == 0);
      if ($urandom_range(11) == 0) begin
        repeat (cfg_entry_timeout < 60 ? cfg_entry_timeout + 1 : 60) send_tick();
      end else begin
        repeat ($urandom_range(2)) send_tick();
      end
      if (lk_mode != MODE_ENTERING) break;
    end
    if (lk_mode == MODE_ERROR || lk_mode == MODE_TIMEOUT) begin
      press_digit(DIGIT_W'($urandom_range(4)), 1'b0);
    end else if (lk_mode == MODE_UNLOCKED && cfg_long_press < 200) begin
      long_press();
    end
  endtask

  // Random phases, each under its own configuration; idle patterns change every two phases
  task automatic test_random();
    int ph;
    int target;
    int t [5];
    int i;
    for (ph = 0; ph < 6; ph++) begin
      wait_drained();
      t[0] = $urandom_range(300);
      for (i = 1; i < 5; i++) t[i] = (t[i-1] + $urandom_range(800) > 4095) ? 4095 :
                                      t[i-1] + $urandom_range(800);
      case (ph)
        0: load_config($urandom_range(40, 5), $urandom_range(20, 1), t[0], t[1], t[2], t[3], t[4]);
        1: load_config(1, 1, 0, t[1], t[2], t[3], 4095);
        2: load_config($urandom_range(30, 2), $urandom_range(30, 2), $urandom_range(4095),
                       $urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                       $urandom_range(4095));
        3: load_config(65535, $urandom_range(20, 1), t[0], t[1], t[2], t[3], t[4]);
        4: load_config($urandom_range(30, 3), 65535, t[0], t[1], t[2], t[3], t[4]);
        default: load_config($urandom_range(40, 5), $urandom_range(20, 1), THRESH_RIGHT_RST,
                             THRESH_UP_RST, THRESH_DOWN_RST, THRESH_LEFT_RST,
                             THRESH_SELECT_RST);
      endcase
      src_idle_pct  = (ph < 2) ? 10 : (ph < 4) ? 70 : 0;
      sink_idle_pct = (ph < 2) ? 70 : (ph < 4) ? 10 : 0;
      target = items_sent + ((ph == 4) ? 100 : 260);
      while (items_sent < target) begin
        if ($urandom_range(9) < 7) run_attempt();
        else repeat ($urandom_range(6, 1)) send_noise();
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    // short hold limit so the setup-mode hold expiry is reachable
    load_config(ENTRY_TIMEOUT_RST, 1, THRESH_RIGHT_RST, THRESH_UP_RST, THRESH_DOWN_RST,
                THRESH_LEFT_RST, THRESH_SELECT_RST);
    test_setup();
    test_code_entry();
    test_long_press();
    wait_drained();
    load_config(1, 1, thr[0], thr[1], thr[2], thr[3], thr[4]);
    test_timeout();
    test_backpressure();
    test_random();
    wait_drained();
    repeat (5) @(posedge clk_i);
    if (fail_count == 0 && lock_results_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("FAIL");
    $finish;
  end

endmodule
